>>> rtl/qfsm_pkg.sv
// ----------------------------------------------------------------------------
// qfsm_pkg
// Shared types and constants of the quad flight supervisor and mixer.
// ----------------------------------------------------------------------------
package qfsm_pkg;

  localparam int unsigned AngleW   = 15;
  localparam int unsigned HoldW    = 10;
  localparam int unsigned CountW   = 11;
  localparam int unsigned MotorW   = 16;
  localparam int unsigned PaddrW   = 4;
  localparam int unsigned PdataW   = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] RegSafeAngle = 2'd0;
  localparam logic [1:0] RegMaxAngle  = 2'd1;
  localparam logic [1:0] RegArmHold   = 2'd2;
  localparam logic [1:0] RegErrHold   = 2'd3;

  localparam logic [AngleW-1:0] SafeAngleRst = AngleW'(1000);
  localparam logic [AngleW-1:0] MaxAngleRst  = AngleW'(2500);
  localparam logic [HoldW-1:0]  ArmHoldRst   = HoldW'(800);
  localparam logic [HoldW-1:0]  ErrHoldRst   = HoldW'(200);

  // external request codes
  localparam logic [1:0] ReqNone   = 2'd0;
  localparam logic [1:0] ReqArm    = 2'd1;
  localparam logic [1:0] ReqDisarm = 2'd2;

  // drive mode codes
  localparam logic [1:0] ModeStopped = 2'd0;
  localparam logic [1:0] ModeUnlock  = 2'd1;
  localparam logic [1:0] ModeAngleEr = 2'd2;
  localparam logic [1:0] ModeFlying  = 2'd3;

  localparam logic [5:0] AllReady = 6'h3F;

  typedef struct packed {
    logic [AngleW-1:0] level_limit;
    logic [AngleW-1:0] tilt_limit;
    logic [HoldW-1:0]  arm_hold_ticks;
    logic [HoldW-1:0]  err_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] drive_mode;
    logic [2:0] flight_state;
    logic       reset_controllers;
  } sup_out_t;

endpackage

>>> rtl/qfsm_cfg.sv
// ----------------------------------------------------------------------------
// qfsm_cfg
// APB register file holding the angle limits and hold tick counts.
// ----------------------------------------------------------------------------
module qfsm_cfg import qfsm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_limit    <= SafeAngleRst;
      cfg_q.tilt_limit     <= MaxAngleRst;
      cfg_q.arm_hold_ticks <= ArmHoldRst;
      cfg_q.err_hold_ticks <= ErrHoldRst;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegSafeAngle: cfg_q.level_limit    <= pwdata[AngleW-1:0];
        RegMaxAngle:  cfg_q.tilt_limit     <= pwdata[AngleW-1:0];
        RegArmHold:   cfg_q.arm_hold_ticks <= pwdata[HoldW-1:0];
        RegErrHold:   cfg_q.err_hold_ticks <= pwdata[HoldW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegSafeAngle: prdata = PdataW'(cfg_q.level_limit);
      RegMaxAngle:  prdata = PdataW'(cfg_q.tilt_limit);
      RegArmHold:   prdata = PdataW'(cfg_q.arm_hold_ticks);
      RegErrHold:   prdata = PdataW'(cfg_q.err_hold_ticks);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/qfsm_supervisor.sv
// ----------------------------------------------------------------------------
// qfsm_supervisor
// Arming state machine with level and over-tilt hold counters.
// ----------------------------------------------------------------------------
module qfsm_supervisor import qfsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  cfg_t        cfg_i,
  input  logic [1:0]  state_request_i,
  input  logic [5:0]  ready_flags_i,
  input  logic [15:0] pitch_angle_i,
  input  logic [15:0] roll_angle_i,
  output sup_out_t    sup_o
);

  typedef enum logic [2:0] {
    StLock     = 3'd0,
    StReady    = 3'd1,
    StUnlock   = 3'd2,
    StFlying   = 3'd3,
    StAngleErr = 3'd4
  } state_e;

  state_e            state_q, state_d, state_req;
  logic [CountW-1:0] level_q, level_d, level_inc;
  logic [CountW-1:0] tilt_q, tilt_d, tilt_inc;
  logic [15:0]       mag_p, mag_r;
  logic              is_level, is_tilted;

  // 16-bit magnitude: -32768 maps to 32768, which is never level
  assign mag_p = pitch_angle_i[15] ? (~pitch_angle_i + 16'd1) : pitch_angle_i;
  assign mag_r = roll_angle_i[15]  ? (~roll_angle_i + 16'd1)  : roll_angle_i;

  assign is_level  = (mag_p <= 16'(cfg_i.level_limit)) && (mag_r <= 16'(cfg_i.level_limit));
  assign is_tilted = (mag_p > 16'(cfg_i.tilt_limit)) || (mag_r > 16'(cfg_i.tilt_limit));

  assign level_inc = level_q + CountW'(1);
  assign tilt_inc  = tilt_q + CountW'(1);

  always_comb begin
    state_req = state_q;
    if (state_request_i == ReqDisarm) begin
      state_req = StLock;
    end else if (state_request_i == ReqArm && state_q == StReady) begin
      state_req = StUnlock;
    end

    state_d = state_req;
    level_d = level_q;
    tilt_d  = tilt_q;
    sup_o.drive_mode        = ModeStopped;
    sup_o.reset_controllers = 1'b0;

    unique case (state_req)
      StUnlock: begin
        sup_o.drive_mode        = ModeUnlock;
        sup_o.reset_controllers = 1'b1;
        if (is_level) begin
          level_d = level_inc;
          if (level_inc > CountW'(cfg_i.arm_hold_ticks)) begin
            level_d = '0;
            state_d = StFlying;
          end
        end else begin
          level_d = '0;
        end
      end
      StAngleErr: begin
        sup_o.drive_mode        = ModeAngleEr;
        sup_o.reset_controllers = 1'b1;
      end
      StFlying: begin
        sup_o.drive_mode = ModeFlying;
        if (is_tilted) begin
          tilt_d = tilt_inc;
          if (tilt_inc > CountW'(cfg_i.err_hold_ticks)) begin
            tilt_d  = '0;
            state_d = StAngleErr;
          end
        end else begin
          tilt_d = '0;
        end
      end
      default: begin
        // lock, ready and any stray code
        if (ready_flags_i == AllReady) begin
          state_d = StReady;
        end else begin
          state_d = StLock;
        end
      end
    endcase

    sup_o.flight_state = state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLock;
      level_q <= '0;
      tilt_q  <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      level_q <= level_d;
      tilt_q  <= tilt_d;
    end
  end

endmodule

>>> rtl/qfsm_mixer.sv
// ----------------------------------------------------------------------------
// qfsm_mixer
// X-quad motor mixer; sums are forced to zero outside flying.
// ----------------------------------------------------------------------------
module qfsm_mixer import qfsm_pkg::*; (
  input  logic              flying_i,
  input  logic [11:0]       throttle_base_i,
  input  logic [12:0]       pitch_correction_i,
  input  logic [12:0]       roll_correction_i,
  input  logic [12:0]       yaw_correction_i,
  input  logic [12:0]       climb_correction_i,
  output logic [MotorW-1:0] motor_front_a_o,
  output logic [MotorW-1:0] motor_front_b_o,
  output logic [MotorW-1:0] motor_rear_a_o,
  output logic [MotorW-1:0] motor_rear_b_o
);

  logic signed [MotorW-1:0] h, p, r, y;

  assign h = $signed({4'b0, throttle_base_i}) + MotorW'(signed'(climb_correction_i));
  assign p = MotorW'(signed'(pitch_correction_i));
  assign r = MotorW'(signed'(roll_correction_i));
  assign y = MotorW'(signed'(yaw_correction_i));

  assign motor_front_a_o = flying_i ? MotorW'(h + p + r - y) : '0;
  assign motor_front_b_o = flying_i ? MotorW'(h - p + r + y) : '0;
  assign motor_rear_a_o  = flying_i ? MotorW'(h - p - r - y) : '0;
  assign motor_rear_b_o  = flying_i ? MotorW'(h + p - r + y) : '0;

endmodule

>>> rtl/quad_flight_supervisor_mixer.sv
// ----------------------------------------------------------------------------
// quad_flight_supervisor_mixer
// Flight supervisor with arming sequence and X-quad motor mixer.
// ----------------------------------------------------------------------------
// One request per control tick enters on the input channel (valid/ready)
// and yields one result on the output channel (valid/ready): drive mode,
// supervisor state, controller reset flag and four motor sums.
// A request is captured in an input register; the state machine and mixer
// evaluate it there, and once the result register is free or being read
// it is loaded while the supervisor state advances. While the receiver
// does not stall, one request per cycle is sustained.
// If the receiver stalls, the result register holds its value and the
// input register keeps the next request; input ready drops only when both
// are full, so the input side never waits on an empty slot.
// Reset clears both valid flags, puts the supervisor in lock with zeroed
// hold counters and loads the register defaults. The user must write the
// APB port (pready tied high) only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module quad_flight_supervisor_mixer import qfsm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        state_request_i,
  input  logic [5:0]        ready_flags_i,
  input  logic [15:0]       pitch_angle_i,
  input  logic [15:0]       roll_angle_i,
  input  logic [11:0]       throttle_base_i,
  input  logic [12:0]       pitch_correction_i,
  input  logic [12:0]       roll_correction_i,
  input  logic [12:0]       yaw_correction_i,
  input  logic [12:0]       climb_correction_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        drive_mode_o,
  output logic [2:0]        flight_state_out_o,
  output logic              reset_controllers_o,
  output logic [MotorW-1:0] motor_front_a_o,
  output logic [MotorW-1:0] motor_front_b_o,
  output logic [MotorW-1:0] motor_rear_a_o,
  output logic [MotorW-1:0] motor_rear_b_o
);

  cfg_t     cfg;
  sup_out_t sup;
  logic     in_vld_q, out_vld_q, advance, in_take;

  logic [1:0]  req_q;
  logic [5:0]  flags_q;
  logic [15:0] pitch_q, roll_q;
  logic [11:0] thr_q;
  logic [12:0] pc_q, rc_q, yc_q, cc_q;

  logic [MotorW-1:0] m1, m2, m3, m4;
  logic [MotorW-1:0] m1_q, m2_q, m3_q, m4_q;
  sup_out_t          sup_q;

  qfsm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign advance    = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;
  assign in_take    = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q   <= state_request_i;
      flags_q <= ready_flags_i;
      pitch_q <= pitch_angle_i;
      roll_q  <= roll_angle_i;
      thr_q   <= throttle_base_i;
      pc_q    <= pitch_correction_i;
      rc_q    <= roll_correction_i;
      yc_q    <= yaw_correction_i;
      cc_q    <= climb_correction_i;
    end
    if (advance) begin
      sup_q <= sup;
      m1_q  <= m1;
      m2_q  <= m2;
      m3_q  <= m3;
      m4_q  <= m4;
    end
  end

  qfsm_supervisor u_sup (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .cfg_i          (cfg),
    .state_request_i(req_q),
    .ready_flags_i  (flags_q),
    .pitch_angle_i  (pitch_q),
    .roll_angle_i   (roll_q),
    .sup_o          (sup)
  );

  qfsm_mixer u_mix (
    .flying_i          (sup.drive_mode == ModeFlying),
    .throttle_base_i   (thr_q),
    .pitch_correction_i(pc_q),
    .roll_correction_i (rc_q),
    .yaw_correction_i  (yc_q),
    .climb_correction_i(cc_q),
    .motor_front_a_o   (m1),
    .motor_front_b_o   (m2),
    .motor_rear_a_o    (m3),
    .motor_rear_b_o    (m4)
  );

  assign out_valid_o         = out_vld_q;
  assign drive_mode_o        = sup_q.drive_mode;
  assign flight_state_out_o  = sup_q.flight_state;
  assign reset_controllers_o = sup_q.reset_controllers;
  assign motor_front_a_o     = m1_q;
  assign motor_front_b_o     = m2_q;
  assign motor_rear_a_o      = m3_q;
  assign motor_rear_b_o      = m4_q;

endmodule
